FILE: design/rgbe_scanline_rle_decoder_top_macros.svh
// Assertion macros for the RGBE scanline RLE decoder.
// Used by rgbe_scanline_rle_decoder_top; expects clk and rst_n in scope.
`ifndef RGBE_SCANLINE_RLE_DECODER_TOP_MACROS_SVH
`define RGBE_SCANLINE_RLE_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define RGBE_RLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RGBE_RLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rgbe_rle_pkg.sv
// Shared types and constants for the RGBE scanline RLE decoder.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package rgbe_rle_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int MIN_WIDTH = 8;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int POS_W     = 13;
  localparam int NUM_CH    = 4;

  localparam logic [7:0] HEADER_MARK = 8'd2;
  localparam logic [7:0] RUN_BASE    = 8'd128;

  localparam logic [2:0] STAT_ACCEPTED   = 3'd0;
  localparam logic [2:0] STAT_LINE_DONE  = 3'd1;
  localparam logic [2:0] STAT_BAD_MARKER = 3'd2;
  localparam logic [2:0] STAT_CLIPPED    = 3'd3;
  localparam logic [2:0] STAT_PIXEL      = 3'd4;

  typedef enum logic [2:0] {
    PH_HEAD0,
    PH_HEAD_REST,
    PH_CODE,
    PH_RUN_VALUE,
    PH_LITERAL,
    PH_READY
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RUN,
    ST_POST
  } ctl_state_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic run_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic run_item;
    logic run_last;
  } sts_t;

endpackage

FILE: design/rgbe_rle_in_if.sv
// Input request channel of the RGBE scanline RLE decoder.
// Depends on rgbe_rle_pkg for field widths.
`timescale 1ns / 1ps

interface rgbe_rle_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [7:0]                    data_byte;
  logic [rgbe_rle_pkg::COL_W-1:0] column;

  modport source (output valid, func, data_byte, column, input ready);
  modport sink   (input valid, func, data_byte, column, output ready);
endinterface

FILE: design/rgbe_rle_out_if.sv
// Result channel of the RGBE scanline RLE decoder.
// No dependencies.
`timescale 1ns / 1ps

interface rgbe_rle_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic [7:0] pixel_exponent;

  modport source (output valid, status, pixel_red, pixel_green, pixel_blue,
                  pixel_exponent, input ready);
  modport sink   (input valid, status, pixel_red, pixel_green, pixel_blue,
                  pixel_exponent, output ready);
endinterface

FILE: design/rgbe_rle_cfg_if.sv
// Configuration write channel of the RGBE scanline RLE decoder.
// Depends on rgbe_rle_pkg for the register width.
`timescale 1ns / 1ps

interface rgbe_rle_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rgbe_rle_pkg::POS_W-1:0] line_width;

  modport source (output valid, line_width, input ready);
  modport sink   (input valid, line_width, output ready);
endinterface

FILE: design/rgbe_scanline_rle_decoder_top.sv
// Top level of the RGBE scanline RLE decoder: controller, datapath, channels.
// Depends on rgbe_rle_pkg, the channel interfaces, rgbe_rle_ctrl, rgbe_rle_dp.
`timescale 1ns / 1ps

// Decodes one adaptive-RLE RGBE scanline from bytes into a 4096-pixel line store
// (four 8-bit RAMs, one per channel) and reads pixels back by column once the
// line is complete. Every request gives exactly one result, registered after
// its accept, decode step and result load; the byte after a run code also
// writes the run's N copies between decode step and result load, one write per
// cycle through the line store's single write port. A request is accepted
// while an earlier result still sits in the output register. The line store
// has no reset; reads of columns never written since power-up return
// unspecified data. line_width is clamped to 8..4096 and must only be written
// while the block is idle; the config port is always ready.
module rgbe_scanline_rle_decoder_top (
  input logic             clk,
  input logic             rst_n,
  rgbe_rle_in_if.sink     in_ch,
  rgbe_rle_out_if.source  out_ch,
  rgbe_rle_cfg_if.sink    cfg_ch
);
  import rgbe_rle_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_acc;
  logic res_plain;
  logic pix_any;

  assign cfg_ch.ready = 1'b1;

  rgbe_rle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rgbe_rle_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_func            (in_ch.func),
    .in_data_byte       (in_ch.data_byte),
    .in_column          (in_ch.column),
    .cfg_we             (cfg_ch.valid),
    .cfg_line_width     (cfg_ch.line_width),
    .out_status         (out_ch.status),
    .out_pixel_red      (out_ch.pixel_red),
    .out_pixel_green    (out_ch.pixel_green),
    .out_pixel_blue     (out_ch.pixel_blue),
    .out_pixel_exponent (out_ch.pixel_exponent)
  );

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign res_plain = out_ch.valid && (out_ch.status != STAT_PIXEL);
  assign pix_any   = |{out_ch.pixel_red, out_ch.pixel_green, out_ch.pixel_blue,
                       out_ch.pixel_exponent};

`include "rgbe_scanline_rle_decoder_top_macros.svh"

  `RGBE_RLE_ASSERT_NXT(a_one_in_flight, in_acc, !in_ch.ready, "request accepted while busy")
  `RGBE_RLE_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_ch.valid || out_ch.ready, "result lost")
  `RGBE_RLE_ASSERT_NXT(a_run_stops, cmd.run_step && sts.run_last, !cmd.run_step, "run overshoot")
  `RGBE_RLE_ASSERT_IMP(a_pix_zero, res_plain, !pix_any, "stray pixel data")

endmodule

FILE: design/rgbe_rle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rgbe_rle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

FILE: design/rgbe_rle_ctrl.sv
// Controller FSM: sequences accept, decode step, run writes and result load.
// Depends on rgbe_rle_pkg.
`timescale 1ns / 1ps

module rgbe_rle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rgbe_rle_pkg::sts_t sts,
  output rgbe_rle_pkg::cmd_t cmd
);
  import rgbe_rle_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = sts.run_item ? ST_RUN : ST_POST;
      ST_RUN:  if (sts.run_last) state_nxt = ST_POST;
      ST_POST: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_RUN:  cmd.run_step = 1'b1;
      ST_POST: cmd.load_out = slot_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: design/rgbe_rle_dp.sv
// Datapath: decode state, line store (one RAM per channel) and result registers.
// Depends on rgbe_rle_pkg and rgbe_rle_ram.
`timescale 1ns / 1ps

module rgbe_rle_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rgbe_rle_pkg::cmd_t              cmd,
  output rgbe_rle_pkg::sts_t              sts,
  input  logic                            in_func,
  input  logic [7:0]                      in_data_byte,
  input  logic [rgbe_rle_pkg::COL_W-1:0]  in_column,
  input  logic                            cfg_we,
  input  logic [rgbe_rle_pkg::POS_W-1:0]  cfg_line_width,
  output logic [2:0]                      out_status,
  output logic [7:0]                      out_pixel_red,
  output logic [7:0]                      out_pixel_green,
  output logic [7:0]                      out_pixel_blue,
  output logic [7:0]                      out_pixel_exponent
);
  import rgbe_rle_pkg::*;

  // configuration
  logic [POS_W-1:0] line_width_r;
  logic [POS_W-1:0] wiu;

  // request being worked on
  logic             item_func_r;
  logic [7:0]       item_byte_r;
  logic [COL_W-1:0] item_col_r;

  // decode state
  phase_t           phase_r, phase_nxt;
  logic [1:0]       header_count_r, header_count_nxt;
  logic [1:0]       channel_r, channel_nxt;
  logic [POS_W-1:0] column_pos_r, column_pos_nxt;
  logic [7:0]       literal_left_r, literal_left_nxt;
  logic [6:0]       run_length_r, run_length_nxt;

  // result
  logic [2:0]       res_status_r, res_status_nxt;
  logic             pix_ok_r, pix_ok_nxt;
  logic             clip_r, clip_nxt;
  logic [2:0]       out_status_r;
  logic [7:0]       out_pix_r [NUM_CH];

  // line store access
  logic             ram_we;
  logic             ram_re;
  logic [7:0]       ram_rdata [NUM_CH];

  logic [POS_W-1:0] pos_inc;
  logic             wr_ok;
  logic             grp_end;
  logic             byte_done;
  logic             line_done;
  logic             clip_any;

  always_comb begin
    if (line_width_r < POS_W'(MIN_WIDTH)) begin
      wiu = POS_W'(MIN_WIDTH);
    end else if (line_width_r > POS_W'(MAX_WIDTH)) begin
      wiu = POS_W'(MAX_WIDTH);
    end else begin
      wiu = line_width_r;
    end
  end

  assign pos_inc = column_pos_r + POS_W'(1);
  assign wr_ok   = column_pos_r < wiu;

  assign sts.run_item = !item_func_r && (phase_r == PH_RUN_VALUE);
  assign sts.run_last = run_length_r == 7'd1;

  always_comb begin
    phase_nxt        = phase_r;
    header_count_nxt = header_count_r;
    channel_nxt      = channel_r;
    column_pos_nxt   = column_pos_r;
    literal_left_nxt = literal_left_r;
    run_length_nxt   = run_length_r;
    res_status_nxt   = res_status_r;
    pix_ok_nxt       = pix_ok_r;
    clip_nxt         = clip_r;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    grp_end          = 1'b0;
    byte_done        = 1'b0;
    line_done        = 1'b0;
    clip_any         = 1'b0;

    if (cmd.exec) begin
      pix_ok_nxt     = 1'b0;
      clip_nxt       = 1'b0;
      res_status_nxt = STAT_ACCEPTED;
      if (item_func_r) begin
        ram_re = 1'b1;
        if (phase_r == PH_READY) begin
          res_status_nxt = STAT_PIXEL;
          pix_ok_nxt     = {1'b0, item_col_r} < wiu;
        end
      end else begin
        case (phase_r)
          PH_HEAD_REST: begin
            if (header_count_r == 2'd2) begin
              header_count_nxt = '0;
              channel_nxt      = '0;
              column_pos_nxt   = '0;
              literal_left_nxt = '0;
              run_length_nxt   = '0;
              phase_nxt        = PH_CODE;
            end else begin
              header_count_nxt = header_count_r + 2'd1;
            end
          end
          PH_CODE: begin
            if (item_byte_r > RUN_BASE) begin
              run_length_nxt = 7'(item_byte_r - RUN_BASE);
              phase_nxt      = PH_RUN_VALUE;
            end else if (item_byte_r != 8'd0) begin
              literal_left_nxt = item_byte_r;
              phase_nxt        = PH_LITERAL;
            end
          end
          PH_RUN_VALUE: begin
            // writes follow in run steps
          end
          PH_LITERAL: begin
            ram_we           = wr_ok;
            clip_any         = !wr_ok;
            column_pos_nxt   = pos_inc;
            literal_left_nxt = literal_left_r - 8'd1;
            grp_end          = literal_left_r == 8'd1;
            byte_done        = 1'b1;
          end
          default: begin
            if (item_byte_r == HEADER_MARK) begin
              header_count_nxt = '0;
              phase_nxt        = PH_HEAD_REST;
            end else begin
              phase_nxt      = PH_HEAD0;
              res_status_nxt = STAT_BAD_MARKER;
            end
          end
        endcase
      end
    end

    if (cmd.run_step) begin
      ram_we         = wr_ok;
      column_pos_nxt = pos_inc;
      run_length_nxt = run_length_r - 7'd1;
      clip_nxt       = clip_r || !wr_ok;
      if (sts.run_last) begin
        clip_any  = clip_r || !wr_ok;
        grp_end   = 1'b1;
        byte_done = 1'b1;
      end
    end

    if (grp_end) begin
      phase_nxt = PH_CODE;
      if (pos_inc >= wiu) begin
        column_pos_nxt = '0;
        if (channel_r == 2'd3) begin
          channel_nxt = '0;
          phase_nxt   = PH_READY;
          line_done   = 1'b1;
        end else begin
          channel_nxt = channel_r + 2'd1;
        end
      end
    end

    if (byte_done) begin
      if (line_done) begin
        res_status_nxt = STAT_LINE_DONE;
      end else if (clip_any) begin
        res_status_nxt = STAT_CLIPPED;
      end else begin
        res_status_nxt = STAT_ACCEPTED;
      end
    end
  end

  for (genvar g = 0; g < NUM_CH; g++) begin : g_ch
    rgbe_rle_ram #(
      .WIDTH (8),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we && (channel_r == 2'(g))),
      .waddr (column_pos_r[COL_W-1:0]),
      .wdata (item_byte_r),
      .re    (ram_re),
      .raddr (item_col_r),
      .rdata (ram_rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= POS_W'(MIN_WIDTH);
      phase_r        <= PH_HEAD0;
      header_count_r <= '0;
      channel_r      <= '0;
      column_pos_r   <= '0;
      literal_left_r <= '0;
      run_length_r   <= '0;
    end else begin
      if (cfg_we) begin
        line_width_r <= cfg_line_width;
      end
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      channel_r      <= channel_nxt;
      column_pos_r   <= column_pos_nxt;
      literal_left_r <= literal_left_nxt;
      run_length_r   <= run_length_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_func_r <= in_func;
      item_byte_r <= in_data_byte;
      item_col_r  <= in_column;
    end
    res_status_r <= res_status_nxt;
    pix_ok_r     <= pix_ok_nxt;
    clip_r       <= clip_nxt;
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      for (int i = 0; i < NUM_CH; i++) begin
        out_pix_r[i] <= pix_ok_r ? ram_rdata[i] : 8'd0;
      end
    end
  end

  assign out_status         = out_status_r;
  assign out_pixel_red      = out_pix_r[0];
  assign out_pixel_green    = out_pix_r[1];
  assign out_pixel_blue     = out_pix_r[2];
  assign out_pixel_exponent = out_pix_r[3];

endmodule

FILE: test/tb_rgbe_scanline_rle_decoder_top.sv
// Testbench for rgbe_scanline_rle_decoder_top: drives bytes and pixel reads,
// predicts every result and compares it field by field.
// Depends on rgbe_rle_pkg, the three channel interfaces and the decoder RTL.
`timescale 1ns / 1ps

module tb_rgbe_scanline_rle_decoder_top;
  import rgbe_rle_pkg::*;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_READ = 1'b1;
  localparam int   STALL_LIMIT = 3000;
  localparam int   HOLD_CYCLES = 200;
  localparam int   DRAIN_CYCLES = 150;
  localparam int   NUM_DIR = 27;
  localparam int   NUM_SEG = 12;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] expo;
  } result_t;

  typedef struct packed {
    logic             func;
    logic [7:0]       data;
    logic [COL_W-1:0] col;
    logic             typed;
    logic [2:0]       status;
  } dir_row_t;

  // typed rows carry a status with all-zero pixel fields
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{FUNC_READ, 8'h00, 12'd0,    1'b1, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'h00, 12'd0,    1'b1, STAT_BAD_MARKER},
    '{FUNC_BYTE, 8'h02, 12'd0,    1'b1, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'hFF, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'h00, 12'hFFF,  1'b0, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'h80, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'h00, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'h85, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'hFF, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'h03, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'h00, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'h01, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'h80, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'hFF, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'hAA, 12'd0,    1'b1, STAT_CLIPPED},
    '{FUNC_BYTE, 8'h88, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'h00, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'h87, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'h7F, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'h02, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'h55, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_BYTE, 8'hC3, 12'd0,    1'b1, STAT_LINE_DONE},
    '{FUNC_READ, 8'h00, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_READ, 8'h00, 12'd7,    1'b0, STAT_ACCEPTED},
    '{FUNC_READ, 8'h00, 12'hFFF,  1'b1, STAT_PIXEL},
    '{FUNC_BYTE, 8'h02, 12'd0,    1'b0, STAT_ACCEPTED},
    '{FUNC_READ, 8'h00, 12'd0,    1'b1, STAT_ACCEPTED}
  };

  localparam logic [POS_W-1:0] SEG_WIDTH [NUM_SEG] =
    '{13'd0, 13'd17, 13'd8191, 13'd9, 13'd4096, 13'd24, 13'd8, 13'd100, 13'd5,
      13'd31, 13'd4095, 13'd12};
  localparam int SEG_ITEMS [NUM_SEG] =
    '{50, 50, 340, 40, 40, 50, 50, 60, 40, 40, 30, 50};

  logic clk;
  logic rst_n;

  rgbe_rle_in_if  in_ch ();
  rgbe_rle_out_if out_ch ();
  rgbe_rle_cfg_if cfg_ch ();

  rgbe_scanline_rle_decoder_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // decoder shadow state
  phase_t           ph;
  logic [1:0]       hdr_cnt;
  logic [1:0]       chan;
  int               col_pos;
  logic [7:0]       lit_left;
  logic [6:0]       run_len;
  logic [POS_W-1:0] width_reg;
  logic [31:0]      line_px [MAX_WIDTH];
  logic [3:0]       px_written [MAX_WIDTH];

  result_t    pending_results [$];
  int         err_count;
  int         stall_cycles;
  logic       row_typed;
  logic [2:0] row_status;
  logic       tx_gaps;
  logic       quiet_tail;
  logic       hold_req;
  logic       rx_calm;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic logic store_byte(int w, logic [7:0] v);
    if (col_pos >= w) return 1'b0;
    line_px[col_pos][chan*8 +: 8] = v;
    px_written[col_pos][chan] = 1'b1;
    return 1'b1;
  endfunction

  // end of a run or literal group; true when the whole line is done
  function automatic logic close_group(int w);
    ph = PH_CODE;
    if (col_pos < w) return 1'b0;
    col_pos = 0;
    if (chan == 2'd3) begin
      chan = 2'd0;
      ph = PH_READY;
      return 1'b1;
    end
    chan = chan + 2'd1;
    return 1'b0;
  endfunction

  function automatic result_t rle_decode_step(logic f, logic [7:0] b, logic [COL_W-1:0] c);
    result_t r;
    logic    clipped;
    logic    done;
    int      w;
    r = '0;
    clipped = 1'b0;
    done = 1'b0;
    w = eff_width();
    if (f == FUNC_READ) begin
      r.status = STAT_ACCEPTED;
      if (ph == PH_READY) begin
        r.status = STAT_PIXEL;
        if (c < w) begin
          r.red   = line_px[c][7:0];
          r.green = line_px[c][15:8];
          r.blue  = line_px[c][23:16];
          r.expo  = line_px[c][31:24];
        end
      end
      return r;
    end
    case (ph)
      PH_HEAD_REST: begin
        if (hdr_cnt == 2'd2) begin
          hdr_cnt = 2'd0;
          chan = 2'd0;
          col_pos = 0;
          lit_left = 8'd0;
          run_len = 7'd0;
          ph = PH_CODE;
        end else begin
          hdr_cnt = hdr_cnt + 2'd1;
        end
      end
      PH_CODE: begin
        if (b > RUN_BASE) begin
          run_len = 7'(b - RUN_BASE);
          ph = PH_RUN_VALUE;
        end else if (b != 8'd0) begin
          lit_left = b;
          ph = PH_LITERAL;
        end
      end
      PH_RUN_VALUE: begin
        for (int k = 0; k < run_len; k++) begin
          if (!store_byte(w, b)) clipped = 1'b1;
          col_pos++;
        end
        run_len = 7'd0;
        done = close_group(w);
      end
      PH_LITERAL: begin
        if (!store_byte(w, b)) clipped = 1'b1;
        col_pos++;
        if (lit_left > 8'd0) lit_left = lit_left - 8'd1;
        if (lit_left == 8'd0) done = close_group(w);
      end
      default: begin
        if (b == HEADER_MARK) begin
          hdr_cnt = 2'd0;
          ph = PH_HEAD_REST;
        end else begin
          ph = PH_HEAD0;
          r.status = STAT_BAD_MARKER;
        end
      end
    endcase
    if (done) r.status = STAT_LINE_DONE;
    else if (clipped) r.status = STAT_CLIPPED;
    return r;
  endfunction

  // next random request, shaped by where the decoder currently is
  task automatic make_item(output logic f, output logic [7:0] b, output logic [COL_W-1:0] c);
    int w;
    int rem;
    int len;
    int pick;
    w = eff_width();
    f = FUNC_BYTE;
    b = 8'($urandom_range(0, 255));
    c = COL_W'($urandom_range(0, 4095));
    pick = $urandom_range(0, 99);
    case (ph)
      PH_READY: begin
        if (pick < 70) begin
          f = FUNC_READ;
          if (pick >= 20) c = COL_W'($urandom_range(0, w - 1));
          if (c < w && px_written[c] != 4'hF) c = '0;
        end else if (pick < 95) begin
          b = HEADER_MARK;
        end
      end
      PH_HEAD0: begin
        if (pick < 5) f = FUNC_READ;
        else if (pick < 93) b = HEADER_MARK;
      end
      PH_CODE: begin
        rem = w - col_pos;
        if (rem < 1) rem = 1;
        if (pick < 5) begin
          f = FUNC_READ;
        end else if (pick < 9) begin
          b = 8'd0;
        end else if (pick < 17) begin
          // any code, may run past the line end
        end else if (rem > 64 && pick < 90) begin
          len = (rem > 127) ? 127 : rem;
          b = 8'(RUN_BASE + len);
        end else begin
          len = (rem > 64) ? $urandom_range(1, 8) : $urandom_range(1, rem);
          b = ($urandom_range(0, 1) != 0) ? 8'(RUN_BASE + len) : 8'(len);
        end
      end
      default: begin
        if (pick < 5) f = FUNC_READ;
      end
    endcase
  endtask

  task automatic send_item(input logic f, input logic [7:0] b, input logic [COL_W-1:0] c,
                           input logic typed, input logic [2:0] st);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    row_typed = typed;
    row_status = st;
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.data_byte <= b;
    in_ch.column <= c;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_width(input logic [POS_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.line_width <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // request and result tracking, watchdog
  always @(posedge clk) begin : track
    result_t want;
    result_t seen;
    logic    moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        width_reg = cfg_ch.line_width;
        moved = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        want = rle_decode_step(in_ch.func, in_ch.data_byte, in_ch.column);
        if (row_typed) begin
          want = '0;
          want.status = row_status;
        end
        pending_results.push_back(want);
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        seen.status = out_ch.status;
        seen.red    = out_ch.pixel_red;
        seen.green  = out_ch.pixel_green;
        seen.blue   = out_ch.pixel_blue;
        seen.expo   = out_ch.pixel_exponent;
        if (pending_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: result with no request pending: status %0d", $realtime, seen.status);
        end else begin
          want = pending_results.pop_front();
          if (want != seen) begin
            err_count++;
            if (err_count <= 10)
              $display("%0t: mismatch exp st %0d r %h g %h b %h e %h, got st %0d r %h g %h b %h e %h",
                       $realtime, want.status, want.red, want.green, want.blue, want.expo,
                       seen.status, seen.red, seen.green, seen.blue, seen.expo);
          end
        end
      end
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // result side: random back-pressure bursts plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!quiet_tail && !rx_calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
      if ($urandom_range(0, 59) == 0) rx_calm = !rx_calm;
    end
  end

  initial begin
    logic             f;
    logic [7:0]       b;
    logic [COL_W-1:0] c;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_BYTE;
    in_ch.data_byte = '0;
    in_ch.column = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.line_width = POS_W'(MIN_WIDTH);
    ph = PH_HEAD0;
    hdr_cnt = '0;
    chan = '0;
    col_pos = 0;
    lit_left = '0;
    run_len = '0;
    width_reg = POS_W'(MIN_WIDTH);
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_px[i] = '0;
      px_written[i] = '0;
    end
    err_count = 0;
    stall_cycles = 0;
    row_typed = 1'b0;
    row_status = STAT_ACCEPTED;
    tx_gaps = 1'b1;
    quiet_tail = 1'b0;
    hold_req = 1'b0;
    rx_calm = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_DIR; i++)
      send_item(DIR_ROWS[i].func, DIR_ROWS[i].data, DIR_ROWS[i].col,
                DIR_ROWS[i].typed, DIR_ROWS[i].status);

    for (int s = 0; s < NUM_SEG; s++) begin
      wait_idle();
      write_width(SEG_WIDTH[s]);
      quiet_tail = (s >= NUM_SEG - 2);
      tx_gaps = !quiet_tail && ($urandom_range(0, 2) != 0);
      if (s == 1) hold_req = 1'b1;
      for (int n = 0; n < SEG_ITEMS[s]; n++) begin
        make_item(f, b, c);
        send_item(f, b, c, 1'b0, STAT_ACCEPTED);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
